>>> hw/rtl/bpc_pkg.sv
// Package for the barometric compensation block: calibration coefficient
// types, the queue head type, pipeline constants and the NVM decode function.
// Used by bpc_front, bpc_back and the top level; depends on nothing.
package bpc_pkg;

  // Depth of the queue between the front and the back part.
  localparam int unsigned QueueDepth = 4;
  // Latency of one split multiplier (partial products, sum, rounding).
  localparam int unsigned MulLat = 3;
  // Register levels from queue pop to the output register.
  localparam int unsigned NumStages = 6 + 4 * MulLat;

  // Configuration register indexes.
  localparam logic [1:0] CfgWord0 = 2'd0;
  localparam logic [1:0] CfgWord1 = 2'd1;
  localparam logic [1:0] CfgWord2 = 2'd2;

  // Output limits.
  localparam logic signed [28:0] TempMax = 29'sd8388607;
  localparam logic signed [28:0] TempMin = -29'sd8388608;
  localparam logic [25:0] PressMax = 26'h3FFFFFF;

  // Decoded calibration coefficients, raw integers before scaling.
  typedef struct packed {
    logic        [15:0] t1;
    logic        [15:0] t2;
    logic signed [7:0]  t3;
    logic signed [16:0] p1;
    logic signed [16:0] p2;
    logic signed [7:0]  p3;
    logic signed [7:0]  p4;
    logic        [15:0] p5;
    logic        [15:0] p6;
    logic signed [7:0]  p7;
    logic signed [7:0]  p8;
    logic signed [15:0] p9;
    logic signed [7:0]  p10;
    logic signed [7:0]  p11;
  } coef_t;

  // Head of the queue as the back part sees it.
  typedef struct packed {
    logic               valid;
    logic signed [24:0] d;
    logic        [23:0] rp;
  } qhead_t;

  // Unpack the 21 NVM bytes; byte k sits at bits 8k+7:8k of its word.
  function automatic coef_t decode(input logic [63:0] w0, input logic [63:0] w1,
                                   input logic [39:0] w2);
    coef_t c;
    c.t1  = w0[15:0];
    c.t2  = w0[31:16];
    c.t3  = $signed(w0[39:32]);
    c.p1  = $signed({w0[55], w0[55:40]}) - 17'sd16384;
    c.p2  = $signed({w1[7], w1[7:0], w0[63:56]}) - 17'sd16384;
    c.p3  = $signed(w1[15:8]);
    c.p4  = $signed(w1[23:16]);
    c.p5  = w1[39:24];
    c.p6  = w1[55:40];
    c.p7  = $signed(w1[63:56]);
    c.p8  = $signed(w2[7:0]);
    c.p9  = $signed(w2[23:8]);
    c.p10 = $signed(w2[31:24]);
    c.p11 = $signed(w2[39:32]);
    return c;
  endfunction

endpackage

>>> hw/rtl/bpc_if.sv
// Valid/ready channel interfaces for the raw sample input and the
// compensated result output. Depends on nothing.
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_press;
  logic [23:0] raw_temp;

  modport source (output valid, output raw_press, output raw_temp, input ready);
  modport sink (input valid, input raw_press, input raw_temp, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] temp_out;
  logic        [25:0] press_out;
  logic               clipped;

  modport source (output valid, output temp_out, output press_out, output clipped,
                  input ready);
  modport sink (input valid, input temp_out, input press_out, input clipped,
                output ready);
endinterface

>>> hw/rtl/bpc_mul.sv
// Signed multiplier split into four partial products, followed by a
// round-to-nearest (ties away from zero) right shift, with registers for the
// partial products, the sum and the result. Depends on nothing but its parameters.
module bpc_mul #(
  parameter int unsigned WA = 16,
  parameter int unsigned WB = 16,
  parameter int unsigned WO = 32,
  parameter int unsigned S  = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [WA-1:0] a_i,
  input  logic signed [WB-1:0] b_i,
  output logic signed [WO-1:0] y_o
);

  localparam int unsigned LA = WA / 2;
  localparam int unsigned HA = WA - LA;
  localparam int unsigned LB = WB / 2;
  localparam int unsigned HB = WB - LB;
  localparam int unsigned WP = WA + WB;

  logic [LA+LB-1:0]          pp_ll_q;
  logic signed [LA+HB:0]     pp_lh_q;
  logic signed [HA+LB:0]     pp_hl_q;
  logic signed [HA+HB-1:0]   pp_hh_q;
  logic signed [WP-1:0]      p_q;
  logic signed [WP-1:0]      p_d;
  logic signed [WP-1:0]      rs;
  logic signed [WO-1:0]      y_q;

  // Sum the partial products back into the full product; the low half of a
  // times the high half of b carries the weight of b's split point, and the
  // other way round.
  assign p_d = WP'($signed({1'b0, pp_ll_q})) + (WP'(pp_lh_q) <<< LB)
             + (WP'(pp_hl_q) <<< LA) + (WP'(pp_hh_q) <<< (LA + LB));

  // Rounding: adding half minus one for negatives and an arithmetic shift
  // rounds the magnitude half up.
  if (S == 0) begin : g_noshift
    assign rs = p_q;
  end else begin : g_shift
    assign rs = (p_q + $signed(WP'(1) << (S - 1)) - $signed(WP'(p_q[WP-1]))) >>> S;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp_ll_q <= a_i[LA-1:0] * b_i[LB-1:0];
      pp_lh_q <= $signed({1'b0, a_i[LA-1:0]}) * $signed(b_i[WB-1:LB]);
      pp_hl_q <= $signed(a_i[WA-1:LA]) * $signed({1'b0, b_i[LB-1:0]});
      pp_hh_q <= $signed(a_i[WA-1:LA]) * $signed(b_i[WB-1:LB]);
      p_q     <= p_d;
      y_q     <= WO'(rs);
    end
  end

  assign y_o = y_q;

endmodule

>>> hw/rtl/bpc_delay.sv
// Enable-gated shift register used to keep operands aligned with the
// multiplier pipeline in the back part. Depends on nothing.
module bpc_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  // Shift one place on every enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

>>> hw/rtl/bpc_front.sv
// Front part: accepts raw sample items, forms the temperature difference
// and holds items in a short queue. Depends on bpc_pkg and bpc_in_if.
module bpc_front #(
  parameter int unsigned Depth = bpc_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  bpc_in_if.sink          in_i,
  input  logic [15:0]     t1_i,
  input  logic            pop_i,
  output bpc_pkg::qhead_t head_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  logic signed [24:0] d_q [Depth];
  logic [23:0]        rp_q [Depth];
  logic [AW-1:0]      wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               push;
  logic signed [24:0] d_new;

  assign in_i.ready = (cnt_q != CW'(Depth));
  assign push       = in_i.valid && in_i.ready;

  // Raw temperature less the scaled T1 coefficient.
  assign d_new = $signed({1'b0, in_i.raw_temp}) - $signed({1'b0, t1_i, 8'h00});

  // Pointer and fill count update.
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      d_q[wr_q]  <= d_new;
      rp_q[wr_q] <= in_i.raw_press;
    end
  end

  assign head_o.valid = (cnt_q != '0);
  assign head_o.d     = d_q[rd_q];
  assign head_o.rp    = rp_q[rd_q];

endmodule

>>> hw/rtl/bpc_back.sv
// Back part: the compensation pipeline from queue head to output register.
// Depends on bpc_pkg, bpc_out_if, bpc_mul and bpc_delay.
module bpc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bpc_pkg::coef_t  coef_i,
  input  bpc_pkg::qhead_t head_i,
  output logic            pop_o,
  bpc_out_if.source       out_o
);

  localparam int unsigned L = bpc_pkg::MulLat;
  localparam int unsigned NS = bpc_pkg::NumStages;

  logic en;
  logic [NS-1:0] vld_q;

  // Level 1 and 2 registers.
  logic signed [41:0] dt2_q;
  logic signed [49:0] dd_q;
  logic [47:0]        rp2_q;
  logic [23:0]        rp1_q;
  logic signed [60:0] tn_q;
  logic signed [56:0] rp2p11_q;
  logic signed [57:0] ddt3;
  // Level 3 registers.
  logic signed [60:0] tr8, tr32;
  logic signed [52:0] tq_q;
  logic signed [28:0] tout_full;
  logic [23:0]        tout_q;
  logic               tclip_q;
  // Polynomial terms.
  logic signed [53:0] t2q;
  logic signed [54:0] t3q;
  logic signed [52:0] tq_dl;
  logic signed [46:0] p6tq, p6tq_dl, p7t2q;
  logic signed [50:0] p2tq, p2tq_dl, p3t2q, p3t2q_dl, p8t3q;
  logic signed [59:0] p10tq, p10tq_dl;
  logic signed [56:0] p4t3q;
  logic signed [46:0] p7t2q_dl;
  // Level 13 registers.
  logic signed [57:0] inner_q;
  logic signed [51:0] suma_q;
  logic signed [60:0] lin_q;
  logic [23:0]        rp_dl;
  logic [47:0]        rp2_dl;
  logic signed [56:0] rp2p11_dl;
  // Raw pressure products.
  logic signed [53:0] rpi;
  logic signed [43:0] rpl;
  logic signed [39:0] rpc;
  logic signed [51:0] suma_dl;
  // Final levels.
  logic signed [55:0] total_q;
  logic [23:0]        tout_dl;
  logic               tclip_dl;
  logic signed [55:0] pr;
  logic signed [39:0] pq;
  logic signed [23:0] temp_q;
  logic [25:0]        press_q;
  logic               clip_q;
  logic [25:0]        press_d;
  logic               pclip;

  // The whole pipeline advances when the output register is free or taken.
  assign en    = !vld_q[NS-1] || out_o.ready;
  assign pop_o = en && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], pop_o};
    end
  end

  // Temperature polynomial, exact at 2^-48, and the raw pressure square.
  assign ddt3 = dd_q * coef_i.t3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dt2_q    <= head_i.d * $signed({1'b0, coef_i.t2});
      dd_q     <= head_i.d * head_i.d;
      rp2_q    <= head_i.rp * head_i.rp;
      rp1_q    <= head_i.rp;
      tn_q     <= (61'(dt2_q) <<< 18) + 61'(ddt3);
      rp2p11_q <= $signed({1'b0, rp2_q}) * coef_i.p11;
    end
  end

  // Rounded working temperature at 2^-40 and the saturated output copy.
  assign tr8       = tn_q + 61'sd128 - $signed({60'd0, tn_q[60]});
  assign tr32      = tn_q + 61'sd2147483648 - $signed({60'd0, tn_q[60]});
  assign tout_full = tr32[60:32];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tq_q <= tr8[60:8];
      if (tout_full > bpc_pkg::TempMax) begin
        tout_q  <= bpc_pkg::TempMax[23:0];
        tclip_q <= 1'b1;
      end else if (tout_full < bpc_pkg::TempMin) begin
        tout_q  <= bpc_pkg::TempMin[23:0];
        tclip_q <= 1'b1;
      end else begin
        tout_q  <= tout_full[23:0];
        tclip_q <= 1'b0;
      end
    end
  end

  // First row of products on the working temperature.
  bpc_mul #(.WA(53), .WB(53), .WO(54), .S(50)) u_t2q (
    .clk_i, .en_i(en), .a_i(tq_q), .b_i(tq_q), .y_o(t2q));
  bpc_mul #(.WA(17), .WB(53), .WO(47), .S(22)) u_p6 (
    .clk_i, .en_i(en), .a_i($signed({1'b0, coef_i.p6})), .b_i(tq_q), .y_o(p6tq));
  bpc_mul #(.WA(17), .WB(53), .WO(51), .S(17)) u_p2 (
    .clk_i, .en_i(en), .a_i(coef_i.p2), .b_i(tq_q), .y_o(p2tq));
  bpc_mul #(.WA(8), .WB(53), .WO(60), .S(0)) u_p10 (
    .clk_i, .en_i(en), .a_i(coef_i.p10), .b_i(tq_q), .y_o(p10tq));

  bpc_delay #(.W(53), .N(L)) u_dl_tq (
    .clk_i, .en_i(en), .d_i(tq_q), .q_o(tq_dl));

  // Second row: cube of the temperature and square-term products.
  bpc_mul #(.WA(54), .WB(53), .WO(55), .S(50)) u_t3q (
    .clk_i, .en_i(en), .a_i(t2q), .b_i(tq_dl), .y_o(t3q));
  bpc_mul #(.WA(8), .WB(54), .WO(47), .S(14)) u_p7 (
    .clk_i, .en_i(en), .a_i(coef_i.p7), .b_i(t2q), .y_o(p7t2q));
  bpc_mul #(.WA(8), .WB(54), .WO(51), .S(10)) u_p3 (
    .clk_i, .en_i(en), .a_i(coef_i.p3), .b_i(t2q), .y_o(p3t2q));

  // Third row: cube-term products.
  bpc_mul #(.WA(8), .WB(55), .WO(51), .S(11)) u_p8 (
    .clk_i, .en_i(en), .a_i(coef_i.p8), .b_i(t3q), .y_o(p8t3q));
  bpc_mul #(.WA(8), .WB(55), .WO(57), .S(5)) u_p4 (
    .clk_i, .en_i(en), .a_i(coef_i.p4), .b_i(t3q), .y_o(p4t3q));

  // Align earlier terms with the cube-term products.
  bpc_delay #(.W(47), .N(2 * L)) u_dl_p6 (
    .clk_i, .en_i(en), .d_i(p6tq), .q_o(p6tq_dl));
  bpc_delay #(.W(51), .N(2 * L)) u_dl_p2 (
    .clk_i, .en_i(en), .d_i(p2tq), .q_o(p2tq_dl));
  bpc_delay #(.W(60), .N(2 * L)) u_dl_p10 (
    .clk_i, .en_i(en), .d_i(p10tq), .q_o(p10tq_dl));
  bpc_delay #(.W(47), .N(L)) u_dl_p7 (
    .clk_i, .en_i(en), .d_i(p7t2q), .q_o(p7t2q_dl));
  bpc_delay #(.W(51), .N(L)) u_dl_p3 (
    .clk_i, .en_i(en), .d_i(p3t2q), .q_o(p3t2q_dl));

  // Coefficient sums: constant part, raw-pressure multiplier and square term.
  always_ff @(posedge clk_i) begin
    if (en) begin
      inner_q <= (58'(coef_i.p1) <<< 32) + 58'(p2tq_dl) + 58'(p3t2q_dl) + 58'(p4t3q);
      suma_q  <= (52'($signed({1'b0, coef_i.p5})) <<< 27) + 52'(p6tq_dl)
               + 52'(p7t2q_dl) + 52'(p8t3q);
      lin_q   <= (61'(coef_i.p9) <<< 40) + 61'(p10tq_dl);
    end
  end

  // Raw pressure operands brought to the level of the coefficient sums.
  bpc_delay #(.W(24), .N(3 + 3 * L)) u_dl_rp (
    .clk_i, .en_i(en), .d_i(rp1_q), .q_o(rp_dl));
  bpc_delay #(.W(48), .N(3 + 3 * L)) u_dl_rp2 (
    .clk_i, .en_i(en), .d_i(rp2_q), .q_o(rp2_dl));
  bpc_delay #(.W(57), .N(2 + 3 * L)) u_dl_rp2p11 (
    .clk_i, .en_i(en), .d_i(rp2p11_q), .q_o(rp2p11_dl));

  // Products with the raw pressure and its powers.
  bpc_mul #(.WA(25), .WB(58), .WO(54), .S(28)) u_rpi (
    .clk_i, .en_i(en), .a_i($signed({1'b0, rp_dl})), .b_i(inner_q), .y_o(rpi));
  bpc_mul #(.WA(49), .WB(61), .WO(44), .S(64)) u_rpl (
    .clk_i, .en_i(en), .a_i($signed({1'b0, rp2_dl})), .b_i(lin_q), .y_o(rpl));
  bpc_mul #(.WA(57), .WB(25), .WO(40), .S(41)) u_rpc (
    .clk_i, .en_i(en), .a_i(rp2p11_dl), .b_i($signed({1'b0, rp_dl})), .y_o(rpc));

  bpc_delay #(.W(52), .N(L)) u_dl_suma (
    .clk_i, .en_i(en), .d_i(suma_q), .q_o(suma_dl));
  bpc_delay #(.W(25), .N(2 + 4 * L)) u_dl_tout (
    .clk_i, .en_i(en), .d_i({tclip_q, tout_q}), .q_o({tclip_dl, tout_dl}));

  // Pressure accumulator at 2^-24 Pa.
  always_ff @(posedge clk_i) begin
    if (en) begin
      total_q <= 56'(suma_dl) + 56'(rpi) + 56'(rpl) + 56'(rpc);
    end
  end

  // Round to 1/256 Pa and clamp into the output range.
  assign pr = total_q + 56'sd32768 - $signed({55'd0, total_q[55]});
  assign pq = pr[55:16];

  always_comb begin
    if (pq < 0) begin
      press_d = '0;
      pclip   = 1'b1;
    end else if (pq > $signed({14'd0, bpc_pkg::PressMax})) begin
      press_d = bpc_pkg::PressMax;
      pclip   = 1'b1;
    end else begin
      press_d = pq[25:0];
      pclip   = 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      temp_q  <= $signed(tout_dl);
      press_q <= press_d;
      clip_q  <= pclip || tclip_dl;
    end
  end

  assign out_o.valid     = vld_q[NS-1];
  assign out_o.temp_out  = temp_q;
  assign out_o.press_out = press_q;
  assign out_o.clipped   = clip_q;

endmodule

>>> hw/rtl/baro_pressure_temp_compensation_unit.sv
// Top level of the barometric pressure and temperature compensation block:
// calibration registers, front queue and back pipeline.
// Depends on bpc_pkg, bpc_if, bpc_front and bpc_back.
//
//   Channel  Dir  Handshake     Item
//   in_i     in   valid/ready   raw_press[23:0], raw_temp[23:0]
//   out_o    out  valid/ready   temp_out[23:0] signed, press_out[25:0], clipped
//   cfg      in   cfg_we_i      cfg_idx_i selects a calibration word, cfg_wdata_i
//
// One item is accepted per cycle while the queue is not full. The pop from
// the queue loads the first of 18 register levels, set by four split
// multipliers in series on the cubic temperature path.
// Reset clears the calibration words, the queue and the valid bits; no
// clearing pass. A stalled output freezes the pipeline; the queue keeps
// taking items until it is full.
module baro_pressure_temp_compensation_unit #(
  parameter int unsigned QueueDepth = bpc_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bpc_in_if.sink      in_i,
  bpc_out_if.source   out_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [63:0]     word0_q, word1_q;
  logic [39:0]     word2_q;
  bpc_pkg::coef_t  coef;
  bpc_pkg::qhead_t head;
  logic            pop;

  // Calibration word registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word0_q <= '0;
      word1_q <= '0;
      word2_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpc_pkg::CfgWord0: word0_q <= cfg_wdata_i;
        bpc_pkg::CfgWord1: word1_q <= cfg_wdata_i;
        bpc_pkg::CfgWord2: word2_q <= cfg_wdata_i[39:0];
        default: ;
      endcase
    end
  end

  assign coef = bpc_pkg::decode(word0_q, word1_q, word2_q);

  bpc_front #(.Depth(QueueDepth)) u_front (
    .clk_i,
    .rst_ni,
    .in_i,
    .t1_i  (coef.t1),
    .pop_i (pop),
    .head_o(head)
  );

  bpc_back u_back (
    .clk_i,
    .rst_ni,
    .coef_i(coef),
    .head_i(head),
    .pop_o (pop),
    .out_o
  );

endmodule
